// ----- rtl/core/acmac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmac_pkg
// Shared types, register indexes and AES byte substitution for the CMAC block.
// ----------------------------------------------------------------------------
package acmac_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int ROUNDS    = 10;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;

	typedef logic [ROUNDS:0][127:0] rk_set_t;

	typedef struct packed {
		logic busy;
		logic subkey_phase;
	} ks_status_t;

	localparam logic [2047:0] SBOX_BITS = {
		128'h637c777bf26b6fc53001672bfed7ab76,
		128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115,
		128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84,
		128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8,
		128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973,
		128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479,
		128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
		128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df,
		128'h8ca1890dbfe6426841992d0fb054bb16
	};

	function automatic logic [7:0] sub_byte(input logic [7:0] b);
		sub_byte = SBOX_BITS[11'(2047 - 8 * int'(b)) -: 8];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]),
			sub_byte(w[7:0])};
	endfunction

endpackage

// ----- rtl/core/acmac_cipher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmac_cipher
// Fully unrolled AES-128 encryption, ten rounds of combinational logic.
// ----------------------------------------------------------------------------
module acmac_cipher (
	input  logic [127:0]           pt,
	input  acmac_pkg::rk_set_t     rk,
	output logic [127:0]           ct
);

	function automatic logic [7:0] xtime(input logic [7:0] v);
		xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] do_round(input logic [127:0] s, input logic mix);
		logic [7:0] sb [16];
		logic [7:0] t  [16];
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) begin
			sb[i] = s[127 - 8 * i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int row = 0; row < 4; row++) begin
				t[row + 4 * c] = acmac_pkg::sub_byte(sb[row + 4 * ((c + row) % 4)]);
			end
		end
		if (mix) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4 * c];
				a1 = t[4 * c + 1];
				a2 = t[4 * c + 2];
				a3 = t[4 * c + 3];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
				t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
				t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
				t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		r = '0;
		for (int i = 0; i < 16; i++) begin
			r[127 - 8 * i -: 8] = t[i];
		end
		do_round = r;
	endfunction

	logic [127:0] st [acmac_pkg::ROUNDS + 1];

	always_comb begin
		st[0] = pt ^ rk[0];
		for (int r = 1; r <= acmac_pkg::ROUNDS; r++) begin
			st[r] = do_round(st[r - 1], r != acmac_pkg::ROUNDS) ^ rk[r];
		end
	end

	assign ct = st[acmac_pkg::ROUNDS];

endmodule

// ----- rtl/core/acmac_keysched.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmac_keysched
// Key registers, iterative round key expansion and K1/K2 subkey derivation.
// ----------------------------------------------------------------------------
module acmac_keysched (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [acmac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [63:0]                        cfg_wdata,
	input  logic [127:0]                       l_value,
	output acmac_pkg::rk_set_t                 rk,
	output logic [127:0]                       k1,
	output logic [127:0]                       k2,
	output acmac_pkg::ks_status_t              status
);

	typedef enum logic [1:0] {KS_IDLE, KS_LOAD, KS_EXPAND, KS_SUBKEY} ks_state_t;

	ks_state_t state_q;
	logic [63:0]  key_high_q, key_low_q;
	logic [127:0] work_q;
	logic [3:0]   step_q;
	acmac_pkg::rk_set_t rk_q;
	logic [127:0] k1_q, k2_q;
	logic [127:0] next_rk;
	logic [127:0] k1_new;
	logic [31:0]  tw;
	logic         key_wr;

	function automatic logic [7:0] rcon(input logic [3:0] i);
		case (i)
			4'd1:    rcon = 8'h01;
			4'd2:    rcon = 8'h02;
			4'd3:    rcon = 8'h04;
			4'd4:    rcon = 8'h08;
			4'd5:    rcon = 8'h10;
			4'd6:    rcon = 8'h20;
			4'd7:    rcon = 8'h40;
			4'd8:    rcon = 8'h80;
			4'd9:    rcon = 8'h1b;
			4'd10:   rcon = 8'h36;
			default: rcon = 8'h00;
		endcase
	endfunction

	function automatic logic [127:0] gf_double(input logic [127:0] v);
		gf_double = {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
	endfunction

	assign key_wr = cfg_we && (cfg_index == acmac_pkg::REG_KEY_HIGH
		|| cfg_index == acmac_pkg::REG_KEY_LOW);

	// one round key per cycle, rotword and subword on the last word
	always_comb begin
		tw = acmac_pkg::sub_word({work_q[23:0], work_q[31:24]}) ^ {rcon(step_q), 24'h0};
		next_rk[127:96] = work_q[127:96] ^ tw;
		next_rk[95:64]  = work_q[95:64] ^ next_rk[127:96];
		next_rk[63:32]  = work_q[63:32] ^ next_rk[95:64];
		next_rk[31:0]   = work_q[31:0] ^ next_rk[63:32];
	end

	assign k1_new = gf_double(l_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= KS_LOAD;
			key_high_q <= '0;
			key_low_q  <= '0;
			step_q     <= '0;
		end else begin
			if (cfg_we && cfg_index == acmac_pkg::REG_KEY_HIGH) begin
				key_high_q <= cfg_wdata;
			end
			if (cfg_we && cfg_index == acmac_pkg::REG_KEY_LOW) begin
				key_low_q <= cfg_wdata;
			end
			if (key_wr) begin
				state_q <= KS_LOAD;
			end else begin
				case (state_q)
					KS_LOAD: begin
						step_q  <= 4'd1;
						state_q <= KS_EXPAND;
					end
					KS_EXPAND: begin
						step_q <= step_q + 4'd1;
						if (step_q == 4'(acmac_pkg::ROUNDS)) begin
							state_q <= KS_SUBKEY;
						end
					end
					KS_SUBKEY: state_q <= KS_IDLE;
					default:   state_q <= KS_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			KS_LOAD: begin
				work_q <= {key_high_q, key_low_q};
				rk_q[0] <= {key_high_q, key_low_q};
			end
			KS_EXPAND: begin
				work_q <= next_rk;
				rk_q[step_q] <= next_rk;
			end
			KS_SUBKEY: begin
				k1_q <= k1_new;
				k2_q <= gf_double(k1_new);
			end
			default: ;
		endcase
	end

	assign rk  = rk_q;
	assign k1  = k1_q;
	assign k2  = k2_q;
	assign status.busy         = state_q != KS_IDLE;
	assign status.subkey_phase = state_q == KS_SUBKEY;

endmodule

// ----- rtl/core/aes128_cmac_tag_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_cmac_tag_top
// AES-128 CMAC over a stream of 16-byte blocks with tag check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one message block per beat (in_valid / in_stall).
//   Byte 0 of the block is the top byte of block_high. last_block ends the
//   message; byte_count and the expected tag are read on that beat only.
//   Output channel (out_valid / out_stall) carries one tag beat per message.
// Throughput: one block per cycle while in_stall is low; the whole AES
//   encryption and the chaining xor sit in one unrolled combinational pass
//   from the ports to the chaining and result registers.
// Tag: registered in the output register, or in the skid register behind it.
// Reset and key writes: the key schedule expands one round key per cycle and
//   then encrypts zero for K1/K2; in_stall is high from reset and from each
//   key register write until K1 and K2 are stored.
// Output stall: a skid register holds a second tag; in_stall rises
//   while that skid register is full, and also while the key schedule is busy.
// ----------------------------------------------------------------------------
module aes128_cmac_tag_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [acmac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                     cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [63:0]                     block_high,
	input  logic [63:0]                     block_low,
	input  logic [4:0]                      byte_count,
	input  logic                            last_block,
	input  logic [63:0]                     expected_high,
	input  logic [63:0]                     expected_low,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [63:0]                     mac_high,
	output logic [63:0]                     mac_low,
	output logic                            tag_match
);

	acmac_pkg::rk_set_t    rk;
	acmac_pkg::ks_status_t ks;
	logic [127:0] k1, k2;
	logic [127:0] chain_q;
	logic [127:0] blk, padded, msg, pt, ct;
	logic [4:0]   cnt;
	logic         accept, out_take, match;
	logic         out_valid_q, skid_valid_q;
	logic [127:0] out_mac_q, skid_mac_q;
	logic         out_match_q, skid_match_q;

	acmac_keysched u_keysched (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.l_value   (ct),
		.rk        (rk),
		.k1        (k1),
		.k2        (k2),
		.status    (ks)
	);

	assign blk = {block_high, block_low};
	assign cnt = (byte_count > 5'd16) ? 5'd16 : byte_count;

	// pad with 0x80 then zeros from the first unused byte
	always_comb begin
		padded = '0;
		for (int i = 0; i < 16; i++) begin
			if (5'(i) < cnt) begin
				padded[127 - 8 * i -: 8] = blk[127 - 8 * i -: 8];
			end else if (5'(i) == cnt) begin
				padded[127 - 8 * i -: 8] = 8'h80;
			end
		end
	end

	always_comb begin
		if (!last_block) begin
			msg = blk;
		end else if (cnt == 5'd16) begin
			msg = blk ^ k1;
		end else begin
			msg = padded ^ k2;
		end
		pt = ks.subkey_phase ? '0 : (chain_q ^ msg);
	end

	acmac_cipher u_cipher (
		.pt (pt),
		.rk (rk),
		.ct (ct)
	);

	assign match    = ct == {expected_high, expected_low};
	assign in_stall = ks.busy | skid_valid_q;
	assign accept   = in_valid & ~in_stall;
	assign out_take = out_valid_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q      <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				chain_q <= last_block ? '0 : ct;
			end
			if (skid_valid_q) begin
				if (out_take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (accept && last_block) begin
				if (out_valid_q && !out_take) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_mac_q   <= skid_mac_q;
				out_match_q <= skid_match_q;
			end
		end else if (accept && last_block) begin
			if (out_valid_q && !out_take) begin
				skid_mac_q   <= ct;
				skid_match_q <= match;
			end else begin
				out_mac_q   <= ct;
				out_match_q <= match;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign mac_high  = out_mac_q[127:64];
	assign mac_low   = out_mac_q[63:0];
	assign tag_match = out_match_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		ks.busy |-> in_stall)
		else $error("input taken during key derivation");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a tag while output is empty");

	a_last_gives_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_block) |=> out_valid)
		else $error("last block produced no tag");

	a_chain_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_block) |=> chain_q == '0)
		else $error("chaining value not cleared after message");

endmodule

// ----- verif/aes128_cmac_tag_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_cmac_tag_chk
// Watches the key port, the block channel and the tag channel of the CMAC block, computes
// each expected tag with its own AES-128 and subkey derivation, and compares
// every tag beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module aes128_cmac_tag_chk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [acmac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                     cfg_wdata,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [63:0]                     block_high,
	input  logic [63:0]                     block_low,
	input  logic [4:0]                      byte_count,
	input  logic                            last_block,
	input  logic [63:0]                     expected_high,
	input  logic [63:0]                     expected_low,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [63:0]                     mac_high,
	input  logic [63:0]                     mac_low,
	input  logic                            tag_match,
	output int                              errors,
	output int                              pending,
	output logic [127:0]                    last_tag
);

	localparam logic [2047:0] S_TABLE = {
		128'h637c777bf26b6fc53001672bfed7ab76,
		128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115,
		128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84,
		128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8,
		128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973,
		128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479,
		128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
		128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df,
		128'h8ca1890dbfe6426841992d0fb054bb16
	};

	typedef struct packed {
		logic [127:0] mac;
		logic         match;
	} tag_beat_t;

	tag_beat_t    tags_due[$];
	logic [127:0] aes_key;
	logic [127:0] chain;
	logic [127:0] sub_k1;
	logic [127:0] sub_k2;
	logic [127:0] rkeys[11];

	function automatic logic [7:0] sbox(input logic [7:0] b);
		return S_TABLE[2047 - 8 * int'(b) -: 8];
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] gf_dbl(input logic [127:0] v);
		return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
	endfunction

	function automatic logic [127:0] aes_encrypt(input logic [127:0] pt);
		logic [7:0]   s[16];
		logic [7:0]   t[16];
		logic [7:0]   a0, a1, a2, a3, all;
		logic [127:0] st;
		st = pt ^ rkeys[0];
		for (int r = 1; r <= 10; r++) begin
			for (int i = 0; i < 16; i++)
				s[i] = st[127 - 8 * i -: 8];
			for (int c = 0; c < 4; c++)
				for (int row = 0; row < 4; row++)
					t[row + 4 * c] = sbox(s[row + 4 * ((c + row) % 4)]);
			if (r != 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4 * c];
					a1 = t[4 * c + 1];
					a2 = t[4 * c + 2];
					a3 = t[4 * c + 3];
					all = a0 ^ a1 ^ a2 ^ a3;
					t[4 * c]     = a0 ^ all ^ xt(a0 ^ a1);
					t[4 * c + 1] = a1 ^ all ^ xt(a1 ^ a2);
					t[4 * c + 2] = a2 ^ all ^ xt(a2 ^ a3);
					t[4 * c + 3] = a3 ^ all ^ xt(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++)
				st[127 - 8 * i -: 8] = t[i];
			st ^= rkeys[r];
		end
		return st;
	endfunction

	// round keys, then L = E(K, 0) and the two doublings
	function automatic void derive_subkeys();
		logic [31:0] w[44];
		logic [31:0] t;
		logic [7:0]  rc;
		{w[0], w[1], w[2], w[3]} = aes_key;
		rc = 8'h01;
		for (int i = 4; i < 44; i++) begin
			t = w[i - 1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
				t ^= {rc, 24'h0};
				rc = xt(rc);
			end
			w[i] = w[i - 4] ^ t;
		end
		for (int i = 0; i < 11; i++)
			rkeys[i] = {w[4 * i], w[4 * i + 1], w[4 * i + 2], w[4 * i + 3]};
		sub_k1 = gf_dbl(aes_encrypt(128'h0));
		sub_k2 = gf_dbl(sub_k1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] blk;
		logic [127:0] mac;
		int           cnt;
		tag_beat_t    due;
		if (!arst_n) begin
			aes_key = '0;
			chain = '0;
			last_tag = '0;
			errors = 0;
			tags_due.delete();
			pending = 0;
			derive_subkeys();
		end else begin
			if (out_valid && !out_stall) begin
				if (tags_due.size() == 0) begin
					$display("%0t: unexpected tag beat mac=%h_%h match=%b", $time,
						mac_high, mac_low, tag_match);
					errors++;
				end else begin
					due = tags_due.pop_front();
					if ({mac_high, mac_low} !== due.mac) begin
						$display("%0t: mac expected %h actual %h_%h", $time, due.mac,
							mac_high, mac_low);
						errors++;
					end
					if (tag_match !== due.match) begin
						$display("%0t: tag_match expected %b actual %b", $time,
							due.match, tag_match);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				blk = {block_high, block_low};
				if (!last_block) begin
					chain = aes_encrypt(chain ^ blk);
				end else begin
					cnt = (byte_count > 16) ? 16 : int'(byte_count);
					if (cnt == 16) begin
						blk ^= sub_k1;
					end else begin
						// pad: 0x80 at the first unused byte, zeros after it
						for (int i = 0; i < 16; i++)
							if (i >= cnt)
								blk[127 - 8 * i -: 8] = (i == cnt) ? 8'h80 : 8'h00;
						blk ^= sub_k2;
					end
					mac = aes_encrypt(chain ^ blk);
					chain = '0;
					last_tag = mac;
					due.mac = mac;
					due.match = (mac == {expected_high, expected_low});
					tags_due.push_back(due);
				end
			end
			pending = tags_due.size();
			if (cfg_we) begin
				if (cfg_index == acmac_pkg::REG_KEY_HIGH) begin
					aes_key[127:64] = cfg_wdata;
					derive_subkeys();
				end else if (cfg_index == acmac_pkg::REG_KEY_LOW) begin
					aes_key[63:0] = cfg_wdata;
					derive_subkeys();
				end
			end
		end
	end

endmodule

// ----- verif/aes128_cmac_tag_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_cmac_tag_top_tb
// Drives keys and messages of random length into the CMAC block under random
// sender gaps and receiver stalls, replays messages with their own tag to hit
// matches, and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module aes128_cmac_tag_top_tb;

	localparam logic [acmac_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [acmac_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int IDLE_LIMIT = 5000;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [acmac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]                     cfg_wdata = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [63:0]                     block_high = '0;
	logic [63:0]                     block_low = '0;
	logic [4:0]                      byte_count = '0;
	logic                            last_block = 1'b0;
	logic [63:0]                     expected_high = '0;
	logic [63:0]                     expected_low = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [63:0]                     mac_high;
	logic [63:0]                     mac_low;
	logic                            tag_match;
	int                              errors;
	int                              pending;
	logic [127:0]                    last_tag;

	int blocks_sent = 0;
	int tx_pct = 20;
	int rx_pct = 20;
	bit hold_req = 0;
	int idle_cycles = 0;

	always #10 clk = ~clk;

	aes128_cmac_tag_top i_dut (.*);

	aes128_cmac_tag_chk i_chk (.*);

	// receiver: random stalls, or one long hold-off on request
	initial begin
		int len;
		bit st;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (80) @(posedge clk);
				hold_req = 0;
			end else begin
				st = ($urandom_range(0, 99) < rx_pct);
				len = (st && $urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
				out_stall <= st;
				repeat (len) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic send_beat(input logic [63:0] hi, input logic [63:0] lo,
		input logic [4:0] cnt, input logic last, input logic [127:0] tag);
		int gap;
		in_valid <= 1'b1;
		block_high <= hi;
		block_low <= lo;
		byte_count <= cnt;
		last_block <= last;
		{expected_high, expected_low} <= tag;
		do @(posedge clk); while (in_stall);
		blocks_sent++;
		if ($urandom_range(0, 99) < tx_pct) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
				: $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic key_write(input logic [acmac_pkg::CFG_IDX_W-1:0] idx,
		input logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// one message of n blocks; on replay it is sent again carrying its own tag
	task automatic run_msg(input int n, input bit replay);
		logic [127:0] blk[8];
		logic [4:0]   cnt[8];
		logic [4:0]   last_cnt;
		int           pick;
		pick = $urandom_range(0, 9);
		last_cnt = (pick < 4) ? 5'd16 : (pick < 8) ? 5'($urandom_range(0, 15))
			: 5'($urandom_range(17, 31));
		for (int i = 0; i < n; i++) begin
			blk[i] = {rnd64(), rnd64()};
			cnt[i] = 5'($urandom_range(0, 31));
		end
		for (int i = 0; i < n - 1; i++)
			send_beat(blk[i][127:64], blk[i][63:0], cnt[i], 1'b0, {rnd64(), rnd64()});
		send_beat(blk[n-1][127:64], blk[n-1][63:0], last_cnt, 1'b1, {rnd64(), rnd64()});
		if (replay) begin
			wait_idle();
			for (int i = 0; i < n - 1; i++)
				send_beat(blk[i][127:64], blk[i][63:0], cnt[i], 1'b0, '0);
			send_beat(blk[n-1][127:64], blk[n-1][63:0], last_cnt, 1'b1, last_tag);
		end
	endtask

	initial begin
		logic [127:0] ones;
		ones = '1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// key still at its reset value of zero
		tx_pct = 0;
		rx_pct = 0;
		send_beat('0, '0, 5'd0, 1'b1, '0);
		send_beat(ones[63:0], ones[63:0], 5'd16, 1'b1, ones);
		wait_idle();

		key_write(acmac_pkg::REG_KEY_HIGH, 64'h2b7e151628aed2a6);
		key_write(acmac_pkg::REG_KEY_LOW, 64'habf7158809cf4f3c);
		send_beat('0, '0, 5'd0, 1'b1, 128'hbb1d6929e95937287fa37d129b756746);
		send_beat(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1,
			128'h070a16b46b4d4144f79bdd9dd04a287c);
		send_beat(ones[63:0], ones[63:0], 5'd1, 1'b1, '0);
		send_beat(ones[63:0], ones[63:0], 5'd15, 1'b1, '0);
		send_beat(ones[63:0], ones[63:0], 5'd17, 1'b1, '0);
		send_beat(ones[63:0], ones[63:0], 5'd31, 1'b1, ones);
		// ignored count and tag on the leading blocks
		send_beat(ones[63:0], '0, 5'd31, 1'b0, ones);
		send_beat('0, ones[63:0], 5'd0, 1'b0, ones);
		send_beat(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd8, 1'b1, '0);
		wait_idle();

		// spare indexes must leave the key alone
		key_write(REG_SPARE_A, ones[63:0]);
		key_write(REG_SPARE_B, ones[63:0]);
		send_beat('0, '0, 5'd0, 1'b1, 128'hbb1d6929e95937287fa37d129b756746);
		wait_idle();

		key_write(acmac_pkg::REG_KEY_HIGH, ones[63:0]);
		key_write(acmac_pkg::REG_KEY_LOW, ones[63:0]);
		send_beat('0, '0, 5'd16, 1'b1, '0);
		send_beat(ones[63:0], ones[63:0], 5'd0, 1'b1, '0);
		wait_idle();

		// fill the block while the receiver holds off
		hold_req = 1;
		for (int i = 0; i < 20; i++)
			send_beat(rnd64(), rnd64(), 5'($urandom_range(0, 31)), 1'b1, '0);
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					key_write(acmac_pkg::REG_KEY_HIGH, rnd64());
					key_write(acmac_pkg::REG_KEY_LOW, rnd64());
					tx_pct = 0;
					rx_pct = 0;
				end
				1: begin
					key_write(acmac_pkg::REG_KEY_LOW, '0);
					tx_pct = 30;
					rx_pct = 30;
				end
				2: begin
					key_write(acmac_pkg::REG_KEY_HIGH, '0);
					tx_pct = 10;
					rx_pct = 50;
				end
				default: begin
					key_write(acmac_pkg::REG_KEY_HIGH, rnd64());
					key_write(acmac_pkg::REG_KEY_LOW, rnd64());
					tx_pct = 50;
					rx_pct = 10;
				end
			endcase
			while (blocks_sent < 60 + 200 * (ph + 1))
				run_msg($urandom_range(1, 6), $urandom_range(0, 4) == 0);
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
